/* src/sdbr_pkg.sv */
package sdbr_pkg;

    // Default number of grids on the display.
    localparam int GRIDS_DEF = 6;

    // Reset value of the blink half period, in ticks.
    localparam logic [15:0] HALF_PERIOD_DEF = 16'd25;

    // Full segment byte, used for a whole grid blink.
    localparam logic [7:0] SEG_ALL = 8'hFF;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;

    // Command codes on the input.
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_SEG   = 3'd1;
    localparam logic [2:0] FUNC_RAW   = 3'd2;
    localparam logic [2:0] FUNC_BLINK = 3'd3;
    localparam logic [2:0] FUNC_CLEAR = 3'd4;
    localparam logic [2:0] FUNC_DIRTY = 3'd5;

    // Segment mode codes.
    localparam logic [1:0] MODE_ON    = 2'd0;
    localparam logic [1:0] MODE_OFF   = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    // Logical to physical grid address map.
    localparam logic [2:0] PHYS_MAP [8] = '{3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd5, 3'd6, 3'd7};

    // Operations that the back end carries out.
    typedef enum logic [2:0] {
        OP_TICK,
        OP_SEG,
        OP_RAW,
        OP_BLINK,
        OP_CLEAR,
        OP_DIRTY
    } t_op;

    // One classified command as it travels through the queue.
    typedef struct packed {
        t_op         op;
        logic [2:0]  grid;
        logic [7:0]  mask;
        logic [1:0]  mode;
        logic [7:0]  raw;
        logic        en;
    } t_cmd;

    // Queue handshake between the front, the queue and the back.
    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qsts;

endpackage

/* src/sdbr_front.sv */
module sdbr_front import sdbr_pkg::*; #(
    parameter int GRIDS = GRIDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_func,
    input  logic [2:0] i_grid,
    input  logic [2:0] i_segment,
    input  logic [1:0] i_seg_mode,
    input  logic [7:0] i_raw_byte,
    input  logic       i_blink_enable,
    input  t_qsts      i_qsts,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic r_vld;
    logic n_keep;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_grid_ok;
    logic w_accept;

    assign w_accept  = start && !busy;
    assign w_grid_ok = ({1'b0, i_grid} < 4'(GRIDS));

    // Classify the command; ignored commands are never queued.
    always_comb begin
        n_cmd.op   = OP_TICK;
        n_cmd.grid = i_grid;
        n_cmd.mask = 8'b1 << i_segment;
        n_cmd.mode = i_seg_mode;
        n_cmd.raw  = i_raw_byte;
        n_cmd.en   = i_blink_enable;
        n_keep     = 1'b0;
        unique case (i_func)
            FUNC_TICK: begin
                n_keep = 1'b1;
            end
            FUNC_SEG: begin
                n_keep   = w_grid_ok;
                // An unknown mode changes no segment but still marks dirty.
                n_cmd.op = (i_seg_mode > MODE_BLINK) ? OP_DIRTY : OP_SEG;
            end
            FUNC_RAW: begin
                n_keep   = w_grid_ok;
                n_cmd.op = OP_RAW;
            end
            FUNC_BLINK: begin
                n_keep   = w_grid_ok;
                n_cmd.op = OP_BLINK;
            end
            FUNC_CLEAR: begin
                n_keep   = 1'b1;
                n_cmd.op = OP_CLEAR;
            end
            FUNC_DIRTY: begin
                n_keep   = 1'b1;
                n_cmd.op = OP_DIRTY;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    // Hold one classified command until the queue has room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= n_keep;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign busy   = r_vld;
    assign o_push = r_vld && !i_qsts.full;
    assign o_cmd  = r_cmd;

endmodule

/* src/sdbr_queue.sv */
module sdbr_queue import sdbr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qctl i_qctl,
    input  t_cmd  i_cmd,
    output t_qsts o_qsts,
    output t_cmd  o_cmd
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wptr;
    logic [QAW-1:0]   r_rptr;
    logic [QAW:0]     r_count;
    logic             w_push;
    logic             w_pop;

    assign w_push = i_qctl.push && !o_qsts.full;
    assign w_pop  = i_qctl.pop && !o_qsts.empty;

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + (QAW+1)'(w_push) - (QAW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_qsts.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_qsts.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rptr];

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qctl.push |-> !o_qsts.full)
        else $error("push into full command queue");

    // The back never pops from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qctl.pop |-> !o_qsts.empty)
        else $error("pop from empty command queue");

    // The count never exceeds the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("command queue count out of range");

endmodule

/* src/sdbr_back.sv */
module sdbr_back import sdbr_pkg::*; #(
    parameter int GRIDS = GRIDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  t_qsts       i_qsts,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [2:0]  o_phys_grid,
    output logic [7:0]  o_seg_data,
    output logic        o_last
);

    localparam int GW = (GRIDS > 1) ? $clog2(GRIDS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [7:0]    r_seg [GRIDS];
    logic [7:0]    n_seg [GRIDS];
    logic [7:0]    r_blk [GRIDS];
    logic [7:0]    n_blk [GRIDS];
    logic [15:0]   r_count;
    logic [15:0]   n_count;
    logic          r_phase;
    logic          n_phase;
    logic          r_dirty;
    logic          n_dirty;
    logic [15:0]   r_half;
    logic [GW-1:0] r_idx;
    logic [GW-1:0] n_idx;
    logic          r_strobe;
    logic [2:0]    r_phys;
    logic [7:0]    r_data;
    logic          r_last;
    logic [GW-1:0] w_g;
    logic [15:0]   w_next;
    logic          w_idx_last;

    assign o_pop      = (r_state == ST_IDLE) && !i_qsts.empty;
    assign w_g        = i_cmd.grid[GW-1:0];
    assign w_next     = r_count + 16'd1;
    assign w_idx_last = (r_idx == GW'(GRIDS - 1));

    // Execute one command, or walk the grids during a refresh.
    always_comb begin
        n_state = r_state;
        n_seg   = r_seg;
        n_blk   = r_blk;
        n_count = r_count;
        n_phase = r_phase;
        n_dirty = r_dirty;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_cmd.op)
                        OP_TICK: begin
                            if (w_next >= r_half) begin
                                n_count = '0;
                                n_phase = !r_phase;
                                n_dirty = 1'b1;
                            end else begin
                                n_count = w_next;
                            end
                            if (n_dirty) begin
                                n_state = ST_SEND;
                                n_idx   = '0;
                            end
                        end
                        OP_SEG: begin
                            priority if (i_cmd.mode == MODE_ON) begin
                                n_seg[w_g] = r_seg[w_g] | i_cmd.mask;
                                n_blk[w_g] = r_blk[w_g] & ~i_cmd.mask;
                            end else if (i_cmd.mode == MODE_OFF) begin
                                n_seg[w_g] = r_seg[w_g] & ~i_cmd.mask;
                                n_blk[w_g] = r_blk[w_g] & ~i_cmd.mask;
                            end else begin
                                n_seg[w_g] = r_seg[w_g] | i_cmd.mask;
                                n_blk[w_g] = r_blk[w_g] | i_cmd.mask;
                            end
                            n_dirty = 1'b1;
                        end
                        OP_RAW: begin
                            if (r_seg[w_g] != i_cmd.raw) begin
                                n_seg[w_g] = i_cmd.raw;
                                n_dirty    = 1'b1;
                            end
                        end
                        OP_BLINK: begin
                            n_blk[w_g] = i_cmd.en ? SEG_ALL : 8'h00;
                            n_dirty    = 1'b1;
                        end
                        OP_CLEAR: begin
                            for (int i = 0; i < GRIDS; i++) begin
                                n_seg[i] = 8'h00;
                                n_blk[i] = 8'h00;
                            end
                            n_dirty = 1'b1;
                        end
                        OP_DIRTY: begin
                            n_dirty = 1'b1;
                        end
                        default: begin
                            n_dirty = r_dirty;
                        end
                    endcase
                end
            end
            ST_SEND: begin
                n_idx = r_idx + 1'b1;
                if (w_idx_last) begin
                    n_dirty = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and the stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_phase  <= 1'b0;
            r_dirty  <= 1'b1;
            r_half   <= HALF_PERIOD_DEF;
            r_idx    <= '0;
            r_strobe <= 1'b0;
            for (int i = 0; i < GRIDS; i++) begin
                r_seg[i] <= 8'h00;
                r_blk[i] <= 8'h00;
            end
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_phase  <= n_phase;
            r_dirty  <= n_dirty;
            r_idx    <= n_idx;
            r_seg    <= n_seg;
            r_blk    <= n_blk;
            r_strobe <= (r_state == ST_SEND);
            if (i_cfg_valid) begin
                r_half <= i_cfg_data;
            end
        end
    end

    // Output register: one grid write per cycle, blinking bits masked in the off phase.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEND) begin
            r_phys <= PHYS_MAP[3'(r_idx)];
            r_data <= r_phase ? r_seg[r_idx] : (r_seg[r_idx] & ~r_blk[r_idx]);
            r_last <= w_idx_last;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_phys_grid = r_phys;
    assign o_seg_data  = r_data;
    assign o_last      = r_last;

    // A refresh only runs while the block is dirty.
    a_send_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND) |-> r_dirty)
        else $error("refresh running while clean");

    // A refresh is one unbroken burst of writes.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_last) |=> r_strobe)
        else $error("refresh burst broken");

    // The final write leaves the block clean and is followed by a gap.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |-> (!r_dirty ##1 !r_strobe))
        else $error("write after final write of refresh");

endmodule

/* src/segment_display_blink_refresh.sv */
// Channel   | Signals                                    | Transfer when
// ----------+--------------------------------------------+-----------------------
// command   | start, busy, i_func .. i_blink_enable      | start && !busy
// config    | i_cfg_valid, o_cfg_ready, i_cfg_data       | i_cfg_valid && o_cfg_ready
// result    | o_strobe, o_phys_grid, o_seg_data, o_last  | o_strobe (one cycle)
//
// Commands that the block acts on pass the front hold register, so a new command is not
// taken while one is held; ignored commands never raise busy and can follow back to back.
// A refreshing tick holds the back in ST_SEND until every grid is written; its writes
// pass the output register and are on the ports on consecutive cycles.
// Synchronous active-low reset clears the stores, counter and phase, sets dirty and
// loads 25 ticks. Results cannot be stalled; busy is high one cycle per queued command
// and stays high while the two-entry command queue is full.
module segment_display_blink_refresh import sdbr_pkg::*; #(
    parameter int GRIDS = GRIDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_grid,
    input  logic [2:0]  i_segment,
    input  logic [1:0]  i_seg_mode,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_blink_enable,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_phys_grid,
    output logic [7:0]  o_seg_data,
    output logic        o_last
);

    t_qctl w_qctl;
    t_qsts w_qsts;
    t_cmd  w_front_cmd;
    t_cmd  w_queue_cmd;
    logic  w_push;
    logic  w_pop;

    // The half period register takes a transfer in any cycle.
    assign o_cfg_ready = 1'b1;

    // Queue controls gathered from the front and the back.
    assign w_qctl = '{push: w_push, pop: w_pop};

    // Command decode and hold.
    sdbr_front #(
        .GRIDS(GRIDS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_grid         (i_grid),
        .i_segment      (i_segment),
        .i_seg_mode     (i_seg_mode),
        .i_raw_byte     (i_raw_byte),
        .i_blink_enable (i_blink_enable),
        .i_qsts         (w_qsts),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    // Command queue between decode and execution.
    sdbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qctl  (w_qctl),
        .i_cmd   (w_front_cmd),
        .o_qsts  (w_qsts),
        .o_cmd   (w_queue_cmd)
    );

    // Store, blink timing and refresh sequencing.
    sdbr_back #(
        .GRIDS(GRIDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_qsts      (w_qsts),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_phys_grid (o_phys_grid),
        .o_seg_data  (o_seg_data),
        .o_last      (o_last)
    );

endmodule
